// ----- hdl/adcseq_pkg.sv -----
package adcseq_pkg;

   localparam int NUM_CHANNELS_DEFAULT  = 8;
   localparam int NUM_BUFFERS_DEFAULT   = 2;
   localparam int NUM_POSITIONS_DEFAULT = 64;

   localparam int MASK_W   = 8;
   localparam int SAMPLE_W = 12;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [SAMPLE_W-1:0] sample;
      logic [2:0]          read_channel;
      logic                read_buffer;
      logic [5:0]          read_position;
   } req_type;

   typedef struct packed {
      logic                       start_conversion;
      logic [2:0]                 channel;
      logic                       buffer_ready;
      logic                       ready_buffer;
      logic signed [SAMPLE_W-1:0] read_data;
   } rsp_type;

endpackage

// ----- hdl/adcseq_ram.sv -----
module adcseq_ram
   import adcseq_pkg::*;
#(
   parameter int WIDTH = SAMPLE_W,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/adc_scan_sequencer_multibuffer_core.sv -----
// ADC scan sequencer with rotating sample buffers.
//
// req channel (valid/ready) carries one command beat: start scan, sample done,
// period tick or read. Every request beat yields exactly one rsp beat, in order.
// csr_wr_en/csr_wr_data load the channel enable mask; write it only while idle.
//
// A response passes the s1 stage register, then the output register. Throughput:
// one beat per cycle while rsp_ready stays high. Each beat does one priority
// pick over the mask plus at most one sample RAM access (a write for sample done,
// a read for a read command); the registered RAM read port sets the first stage.
//
// Reset clears the active channel, buffer and position counters and the mask.
// The sample RAM is not cleared; an entry reads back garbage until written.
// When rsp_ready is low the output register holds its beat, the middle stage
// still fills, and req_ready drops once both stages are full. Accesses to the
// RAM happen at distinct edges, so a read always sees an earlier write.
module adc_scan_sequencer_multibuffer_core
   import adcseq_pkg::*;
#(
   parameter int NUM_CHANNELS  = NUM_CHANNELS_DEFAULT,
   parameter int NUM_BUFFERS   = NUM_BUFFERS_DEFAULT,
   parameter int NUM_POSITIONS = NUM_POSITIONS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [MASK_W-1:0] csr_wr_data
);

   localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int BUF_W       = $clog2(NUM_BUFFERS);
   localparam int POS_W       = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
   localparam int STORE_DEPTH = NUM_CHANNELS * NUM_BUFFERS * NUM_POSITIONS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              act_valid_ff, act_valid_in;
   logic [CH_W-1:0]   act_ch_ff, act_ch_in;
   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   logic              s1_valid_ff, s1_valid_in;
   rsp_type           s1_rsp_ff, s1_rsp_in;
   logic              s1_rd_ok_ff, s1_rd_ok_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              s1_adv;
   logic              found;
   logic [CH_W-1:0]   next_ch;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // lowest enabled channel above the active one (or from 0 when none active)
   always_comb begin
      found   = 1'b0;
      next_ch = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (!found && mask_ff[c] && (!act_valid_ff || c > int'(act_ch_ff))) begin
            found   = 1'b1;
            next_ch = CH_W'(c);
         end
      end
   end

   assign ram_wr_addr = ADDR_W'((int'(act_ch_ff) * NUM_BUFFERS + int'(buf_ff))
                                * NUM_POSITIONS + int'(pos_ff));
   assign ram_rd_addr = ADDR_W'((int'(req_data.read_channel) * NUM_BUFFERS
                                 + int'(req_data.read_buffer)) * NUM_POSITIONS
                                + int'(req_data.read_position));

   always_comb begin
      mask_in      = csr_wr_en ? csr_wr_data : mask_ff;
      act_valid_in = act_valid_ff;
      act_ch_in    = act_ch_ff;
      buf_in       = buf_ff;
      pos_in       = pos_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      s1_rsp_in    = s1_rsp_ff;
      s1_rd_ok_in  = s1_rd_ok_ff;
      if (accept) begin
         s1_rsp_in   = '0;
         s1_rd_ok_in = 1'b0;
         unique case (req_data.cmd)
            CMD_START: begin
               if (found) begin
                  act_valid_in               = 1'b1;
                  act_ch_in                  = next_ch;
                  s1_rsp_in.start_conversion = 1'b1;
                  s1_rsp_in.channel          = 3'(next_ch);
               end
            end
            CMD_SAMPLE: begin
               // no channel active: drop the sample
               if (act_valid_ff) begin
                  ram_wr_en = 1'b1;
                  if (found) begin
                     act_valid_in               = 1'b1;
                     act_ch_in                  = next_ch;
                     s1_rsp_in.start_conversion = 1'b1;
                     s1_rsp_in.channel          = 3'(next_ch);
                  end
               end
            end
            CMD_TICK: begin
               // full 8-bit mask counts, even bits beyond the channel count
               if (mask_ff != '0) begin
                  act_valid_in = 1'b0;
                  act_ch_in    = '0;
                  if (pos_ff == POS_W'(NUM_POSITIONS - 1)) begin
                     pos_in                 = '0;
                     buf_in                 = (buf_ff == BUF_W'(NUM_BUFFERS - 1)) ?
                                              '0 : buf_ff + 1'b1;
                     s1_rsp_in.buffer_ready = 1'b1;
                     s1_rsp_in.ready_buffer = buf_ff[0];
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
            end
            CMD_READ: begin
               s1_rd_ok_in = (int'(req_data.read_channel) < NUM_CHANNELS) &&
                             (int'(req_data.read_buffer) < NUM_BUFFERS) &&
                             (int'(req_data.read_position) < NUM_POSITIONS);
               ram_rd_en   = s1_rd_ok_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      rsp_data_in = rsp_data_ff;
      if (s1_adv) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in           = s1_rsp_ff;
         rsp_data_in.read_data = s1_rd_ok_ff ? ram_rd_data : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         act_valid_ff <= 1'b0;
         act_ch_ff    <= '0;
         buf_ff       <= '0;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         act_valid_ff <= act_valid_in;
         act_ch_ff    <= act_ch_in;
         buf_ff       <= buf_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_rsp_ff   <= s1_rsp_in;
      s1_rd_ok_ff <= s1_rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   adcseq_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.sample),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/adcseq_checker.sv -----
module adcseq_checker
   import adcseq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // outputs come up empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // when a taken request has gone through the s1 register, the output register is never empty:
   // it holds either this beat or an older one stalled by the receiver
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("response missing two cycles after request");

   // read data only on read responses, which never request or flag
   a_read_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_data != '0 |->
         !rsp_data.start_conversion && !rsp_data.buffer_ready)
      else $error("read data mixed with scan result");

endmodule

bind adc_scan_sequencer_multibuffer_core adcseq_checker u_adcseq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
